// ----- design/vmi_pkg.sv -----
`default_nettype none

package vmi_pkg;

    // Width of the magnitude result
    localparam int OUT_W = 16;

    typedef logic [OUT_W-1:0] length_t;

endpackage

`default_nettype wire

// ----- design/vmi_sample_if.sv -----
`default_nettype none

interface vmi_sample_if #(
    parameter int W = 16
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] rate_x;
    logic signed [W-1:0] rate_y;
    logic signed [W-1:0] rate_z;

    modport source (output valid, output rate_x, output rate_y, output rate_z, input ready);
    modport sink   (input valid, input rate_x, input rate_y, input rate_z, output ready);
endinterface

`default_nettype wire

// ----- design/vmi_length_if.sv -----
`default_nettype none

interface vmi_length_if;
    import vmi_pkg::*;

    logic    valid;
    logic    ready;
    length_t vector_length;

    modport source (output valid, output vector_length, input ready);
    modport sink   (input valid, input vector_length, output ready);
endinterface

`default_nettype wire

// ----- design/vector_magnitude_isqrt.sv -----
// Channel   Dir   Payload                          Transfer
// sample    in    rate_x, rate_y, rate_z (signed)  valid & ready
// length    out   vector_length (16b unsigned)     valid & ready
//
// One sample per cycle while the length sink keeps up. The stages are abs,
// square, sum, then one root digit per stage over SAMPLE_WIDTH + 1 stages,
// then the output register. Reset clears only the valid bits. The whole
// pipe freezes while a result waits at the output, so nothing is dropped or
// repeated under stalls.
`default_nettype none

module vector_magnitude_isqrt #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    vmi_sample_if.sink    sample,
    vmi_length_if.source  length
);
    import vmi_pkg::*;

    localparam int W     = SAMPLE_WIDTH;
    localparam int RW    = W + 1;          // root width
    localparam int RAD_W = 2 * RW;         // radicand width
    localparam int REM_W = RW + 2;         // partial remainder width
    localparam int NS    = RW + 1;         // root stages incl. load stage

    logic advance;

    // stage A: magnitudes
    logic         a_vld_reg;
    logic [W-1:0] mag_x_reg, mag_y_reg, mag_z_reg;
    // stage B: squares
    logic           b_vld_reg;
    logic [2*W-1:0] sq_x_reg, sq_y_reg, sq_z_reg;
    // root stages
    logic             rt_vld_reg [NS];
    logic [RAD_W-1:0] rad_reg    [NS];
    logic [REM_W-1:0] rem_reg    [NS];
    logic [RW-1:0]    root_reg   [NS];
    logic [RAD_W-1:0] rad_next   [NS];
    logic [REM_W-1:0] rem_next   [NS];
    logic [RW-1:0]    root_next  [NS];
    logic [REM_W-1:0] rem_sh     [NS-1];
    logic [REM_W-1:0] trial      [NS-1];
    logic             ge         [NS-1];
    // output
    logic                  out_vld_reg;
    length_t               len_reg;
    length_t               len_next;
    logic [RW+OUT_W-1:0]   root_ext;

    function automatic logic [W-1:0] abs_mag(input logic [W-1:0] v);
        abs_mag = v[W-1] ? W'(~v + 1'b1) : v;
    endfunction

    assign advance       = !out_vld_reg || length.ready;
    assign sample.ready  = advance;
    assign length.valid  = out_vld_reg;
    assign length.vector_length = len_reg;

    always_comb
    begin
        rad_next[0]  = RAD_W'({2'b00, sq_x_reg}) + RAD_W'({2'b00, sq_y_reg})
                     + RAD_W'({2'b00, sq_z_reg});
        rem_next[0]  = '0;
        root_next[0] = '0;
        for (int k = 0; k < NS - 1; k++)
        begin
            // bring down the next two radicand bits and try root*4 + 1
            rem_sh[k] = {rem_reg[k][REM_W-3:0], rad_reg[k][RAD_W-1 -: 2]};
            trial[k]  = {root_reg[k], 2'b01};
            ge[k]     = rem_sh[k] >= trial[k];
            rem_next[k+1]  = ge[k] ? rem_sh[k] - trial[k] : rem_sh[k];
            root_next[k+1] = {root_reg[k][RW-2:0], ge[k]};
            rad_next[k+1]  = {rad_reg[k][RAD_W-3:0], 2'b00};
        end
    end

    always_comb
    begin
        root_ext = {{OUT_W{1'b0}}, root_reg[NS-1]};
        len_next = (|root_ext[RW+OUT_W-1:OUT_W]) ? '1 : root_ext[OUT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg   <= 1'b0;
            b_vld_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
            for (int k = 0; k < NS; k++)
            begin
                rt_vld_reg[k] <= 1'b0;
            end
        end
        else if (advance)
        begin
            a_vld_reg     <= sample.valid;
            b_vld_reg     <= a_vld_reg;
            rt_vld_reg[0] <= b_vld_reg;
            for (int k = 1; k < NS; k++)
            begin
                rt_vld_reg[k] <= rt_vld_reg[k-1];
            end
            out_vld_reg   <= rt_vld_reg[NS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            mag_x_reg <= abs_mag(sample.rate_x);
            mag_y_reg <= abs_mag(sample.rate_y);
            mag_z_reg <= abs_mag(sample.rate_z);
            sq_x_reg  <= mag_x_reg * mag_x_reg;
            sq_y_reg  <= mag_y_reg * mag_y_reg;
            sq_z_reg  <= mag_z_reg * mag_z_reg;
            for (int k = 0; k < NS; k++)
            begin
                rad_reg[k]  <= rad_next[k];
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
            end
            len_reg <= len_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/vmi_checker.sv -----
`default_nettype none

module vmi_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] out_length
);
    // a waiting result holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_length))
        else $error("result changed while stalled");

    // an empty or draining output lets a sample in
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid || out_ready |-> in_ready)
        else $error("input blocked with output free");

    // a stalled output freezes the pipe
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while output stalled");

    // a stall with no input keeps the waiting result
    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready && !in_valid |=> out_valid)
        else $error("stalled result lost");

endmodule

bind vector_magnitude_isqrt vmi_checker u_vmi_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (sample.valid),
    .in_ready   (sample.ready),
    .out_valid  (length.valid),
    .out_ready  (length.ready),
    .out_length (length.vector_length)
);

`default_nettype wire

// ----- test/magnitude_monitor.sv -----
module magnitude_monitor #(
    parameter int SW = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    vmi_sample_if        sample,
    vmi_length_if        length,
    output int           errors,
    output int           pending,
    output int           checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import vmi_pkg::*;

    typedef struct {
        logic [SW-1:0] x;
        logic [SW-1:0] y;
        logic [SW-1:0] z;
        length_t       len;
    } rate_len_t;

    rate_len_t expected_lengths[$];

    int err_cnt = 0;
    int chk_cnt = 0;
    int q_cnt   = 0;

    assign errors  = err_cnt;
    assign pending = q_cnt;
    assign checked = chk_cnt;

    // Magnitude of a two's complement axis sample; the most negative value
    // wraps to 2**(SW-1), which is the right unsigned magnitude.
    function automatic logic [63:0] axis_mag(input logic [SW-1:0] raw);
        logic [SW-1:0] neg;
        neg = ~raw + 1'b1;
        if (raw[SW-1])
            return 64'(neg);
        return 64'(raw);
    endfunction

    // Floor square root of x^2 + y^2 + z^2, built one root bit at a time
    // from the top, clamped to the output width.
    function automatic length_t isqrt_of_squares(input logic [SW-1:0] x,
                                                 input logic [SW-1:0] y,
                                                 input logic [SW-1:0] z);
        logic [63:0] sq_sum;
        logic [63:0] root;
        logic [63:0] trial;
        sq_sum = axis_mag(x) * axis_mag(x) + axis_mag(y) * axis_mag(y)
                 + axis_mag(z) * axis_mag(z);
        root = '0;
        for (int i = 31; i >= 0; i--)
        begin
            trial = root | (64'd1 << i);
            if (trial * trial <= sq_sum)
                root = trial;
        end
        if (root > 64'((1 << OUT_W) - 1))
            return '1;
        return length_t'(root);
    endfunction

    task automatic report(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        err_cnt++;
    endtask

    always @(posedge clk)
    begin
        rate_len_t head;
        rate_len_t fresh;
        if (rst_n)
        begin
            if (sample.valid && sample.ready)
            begin
                fresh.x   = sample.rate_x;
                fresh.y   = sample.rate_y;
                fresh.z   = sample.rate_z;
                fresh.len = isqrt_of_squares(sample.rate_x, sample.rate_y, sample.rate_z);
                expected_lengths.push_back(fresh);
            end
            if (length.valid && length.ready)
            begin
                if (expected_lengths.size() == 0)
                    report($sformatf("unexpected length %0d with no sample pending",
                                     length.vector_length));
                else
                begin
                    head = expected_lengths.pop_front();
                    chk_cnt++;
                    if (length.vector_length !== head.len)
                        report($sformatf("vector_length got %0d, want %0d for (%0d,%0d,%0d)",
                                         length.vector_length, head.len,
                                         $signed(head.x), $signed(head.y), $signed(head.z)));
                end
            end
            q_cnt = expected_lengths.size();
        end
    end

endmodule

// ----- test/tb.sv -----
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import vmi_pkg::*;

    localparam int SAMPLE_WIDTH = 16;
    localparam int N_RANDOM     = 900;
    localparam int IDLE_LIMIT   = 3000;
    localparam int DRAIN_CYCLES = 60;

    typedef logic signed [SAMPLE_WIDTH-1:0] rate_t;

    logic clk = 1'b0;
    logic rst_n;
    logic calm = 1'b0;      // no source gaps and no new sink stalls while set

    int errors;
    int pending;
    int checked;
    int n_directed = 0;
    int idle_cycles = 0;

    vmi_sample_if #(.W(SAMPLE_WIDTH)) sample();
    vmi_length_if                     length();

    vector_magnitude_isqrt #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample),
        .length (length)
    );

    magnitude_monitor #(
        .SW(SAMPLE_WIDTH)
    ) mon (
        .clk     (clk),
        .rst_n   (rst_n),
        .sample  (sample),
        .length  (length),
        .errors  (errors),
        .pending (pending),
        .checked (checked)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic rate_t rand_rate();
        case ($urandom_range(0, 5))
            0, 1:    return rate_t'($urandom);
            2:       return rate_t'(int'($urandom_range(0, 127)) - 64);
            3:       return rate_t'(32767 - int'($urandom_range(0, 15)));
            4:       return rate_t'(-32768 + int'($urandom_range(0, 15)));
            default: return rate_t'(int'($urandom_range(0, 2)) - 1);
        endcase
    endfunction

    // Called at a rising edge; returns at the edge where the transfer happens.
    // valid stays high into the next call when that one has no gap.
    task automatic send_sample(input rate_t x, input rate_t y, input rate_t z);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            sample.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample.valid  <= 1'b1;
        sample.rate_x <= x;
        sample.rate_y <= y;
        sample.rate_z <= z;
        @(posedge clk);
        while (!sample.ready)
            @(posedge clk);
    endtask

    task automatic directed(input rate_t x, input rate_t y, input rate_t z);
        send_sample(x, y, z);
        n_directed++;
    endtask

    // Length sink: random stalls of random length, none begun while calm.
    initial
    begin
        int stall_left;
        stall_left = 0;
        length.ready = 1'b0;
        @(posedge clk);
        forever
        begin
            if (stall_left > 0)
            begin
                length.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                length.ready <= 1'b1;
                if (!calm && $urandom_range(0, 99) < 30)
                    stall_left = pick_gap();
            end
            @(posedge clk);
        end
    end

    // Watchdog: too long without any transfer on either channel.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((sample.valid && sample.ready) || (length.valid && length.ready))
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Timeout after %0d cycles without a transfer", idle_cycles);
                $display("Mismatches found");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        sample.valid  = 1'b0;
        sample.rate_x = '0;
        sample.rate_y = '0;
        sample.rate_z = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero, full scale, most negative, small and exact-root cases
        directed(0, 0, 0);
        directed(0, 0, 1);
        directed(-1, 0, 0);
        directed(1, 1, 0);
        directed(-1, -1, -1);
        directed(32767, 0, 0);
        directed(-32768, 0, 0);
        directed(0, -32768, 0);
        directed(0, 0, -32768);
        directed(0, 32767, 0);
        directed(0, 0, 32767);
        directed(-32768, -32768, -32768);
        directed(32767, 32767, 32767);
        directed(32767, -32768, 32767);
        directed(-32768, 32767, -32768);
        directed(3, 4, 0);
        directed(2, -3, 6);
        directed(12, -16, 0);
        directed(-100, 0, 0);
        directed(99, 0, 14);
        directed(16'sh5555, -16'sh5556, 16'sh2aaa);

        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i % 100 == 0)
                calm = ($urandom_range(0, 3) == 0);
            send_sample(rand_rate(), rand_rate(), rand_rate());
        end
        sample.valid <= 1'b0;
        calm = 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Drove %0d directed and %0d random samples; %0d lengths compared.",
                 n_directed, N_RANDOM, checked);
        $display("Axes spanned zero, unit, full-scale and most-negative values ",
                 "under source gaps and sink stalls.");
        if (errors == 0 && pending == 0)
            $display("No mismatches found");
        else
        begin
            $display("%0d errors, %0d lengths never returned", errors, pending);
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ----- vector_magnitude_isqrt.f -----
design/vmi_pkg.sv
design/vmi_sample_if.sv
design/vmi_length_if.sv
design/vector_magnitude_isqrt.sv
design/vmi_checker.sv
test/magnitude_monitor.sv
test/tb.sv
